/* rtl/kerb_pkg.sv */
package kerb_pkg;

    localparam int SLOT_MAX = 6;

    localparam logic [7:0] USE_ENTER = 8'h58;
    localparam logic [7:0] USE_F12   = 8'h45;
    localparam logic [7:0] USE_LEFT  = 8'h50;
    localparam logic [7:0] USE_RIGHT = 8'h4F;
    localparam logic [7:0] USE_DOWN  = 8'h51;
    localparam logic [7:0] USE_UP    = 8'h52;
    localparam logic [7:0] USE_PGUP  = 8'h4B;
    localparam logic [7:0] USE_PGDN  = 8'h4E;

    localparam logic [1:0] CFG_DEBOUNCE_MAX = 2'd0;
    localparam logic [1:0] CFG_JOY_LOW      = 2'd1;
    localparam logic [1:0] CFG_JOY_HIGH     = 2'd2;
    localparam logic [1:0] CFG_DETENT_STEPS = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_OUT
    } t_state;

    // Order in which the non-matrix keys are offered to the list.
    typedef enum logic [2:0] {
        EX_ENTER,
        EX_F12,
        EX_LEFT,
        EX_RIGHT,
        EX_DOWN,
        EX_UP,
        EX_PAGE
    } t_extra;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } t_push;

    // Keymap of the 4x4 matrix; positions outside it are unmapped.
    function automatic logic [7:0] usage_code(input logic [2:0] row, input logic [2:0] col);
        logic [7:0] code;
        code = 8'h00;
        if (row < 3'd4 && col < 3'd4) begin
            unique case ({row[1:0], col[1:0]})
                4'd1:    code = 8'h68;
                4'd2:    code = 8'h69;
                4'd4:    code = 8'h6A;
                4'd5:    code = 8'h6B;
                4'd6:    code = 8'h6C;
                4'd7:    code = 8'h6D;
                4'd8:    code = 8'h6E;
                4'd9:    code = 8'h6F;
                4'd10:   code = 8'h70;
                4'd11:   code = 8'h71;
                4'd13:   code = 8'h72;
                4'd15:   code = 8'h73;
                default: code = 8'h00;
            endcase
        end
        return code;
    endfunction

    // Quadrature transition step, indexed by {previous A, previous B, A, B}.
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] s;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default:                  s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/keypad_encoder_report_builder.sv */
// Keypad, encoder and joystick report builder.
// One input transfer on the s-side stream is one scan tick; tdata carries, from bit 0 up,
// the raw key mask, encoder A, B and switch, touch, joystick X and Y, and host ready.
// When host ready is set the tick yields one transfer on the m-side stream holding the
// six HID usage slots and the slot count; otherwise it yields nothing.
// Key integrators and stable flags live in a single state memory, walked one key per
// cycle with read, update and write-back overlapped; the encoder accumulator is updated
// as the tick is taken. A tick walks the keys, then offers the seven extra keys one at a
// time and loads the output register. The input is taken again only once the report is
// loaded (or, with host ready clear, once the walk is over), so a tick is never taken
// while the last is still in work. A stalled receiver holds the report in the output
// register; the next tick is still accepted and is held at its final load until the
// register frees.
// Reset is synchronous and active low: it restores the register defaults, clears the
// valid bits that make every key read as idle, and empties the output register.
// Configuration writes are taken at any edge with the write enable high and must
// only be issued while the block is idle.
module keypad_encoder_report_builder
    import kerb_pkg::*;
#(
    parameter int ROWS         = 4,
    parameter int COLS         = 4,
    parameter int REPORT_SLOTS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mask[15:0], enc_a, enc_b, enc_switch_n, touch_level, joy_x[11:0], joy_y[11:0],
    // host_ready, zero padding
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // key_slot_0 .. key_slot_5 (8 bits each), key_count[2:0], zero padding
    output logic [55:0] m_axis_tdata
);

    logic [2:0]  r_debounce_max;
    logic [11:0] r_joy_low;
    logic [11:0] r_joy_high;
    logic [6:0]  r_detent_steps;

    t_state r_state, n_state;
    t_extra r_extra, n_extra;

    logic [15:0] r_mask;
    logic        r_sw_n;
    logic        r_touch;
    logic [11:0] r_joy_x;
    logic [11:0] r_joy_y;
    logic        r_ready;

    logic [7:0] r_list [SLOT_MAX];
    logic [2:0] r_cnt;

    logic       r_out_valid;
    logic [7:0] r_out_slot [SLOT_MAX];
    logic [2:0] r_out_cnt;

    logic              accept;
    logic              scan_done;
    t_push             scan_push;
    t_push             tail_push;
    t_push             push;
    logic              page_clear;
    logic              load_out;
    logic signed [7:0] det_acc;
    logic [6:0]        steps;
    logic signed [8:0] acc_w;
    logic signed [8:0] steps_w;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_max <= 3'd5;
            r_joy_low      <= 12'd900;
            r_joy_high     <= 12'd3200;
            r_detent_steps <= 7'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_MAX: r_debounce_max <= i_cfg_wdata[2:0];
                CFG_JOY_LOW:      r_joy_low      <= i_cfg_wdata;
                CFG_JOY_HIGH:     r_joy_high     <= i_cfg_wdata;
                CFG_DETENT_STEPS: r_detent_steps <= i_cfg_wdata[6:0];
                default:          r_debounce_max <= r_debounce_max;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mask  <= s_axis_tdata[15:0];
            r_sw_n  <= s_axis_tdata[18];
            r_touch <= s_axis_tdata[19];
            r_joy_x <= s_axis_tdata[31:20];
            r_joy_y <= s_axis_tdata[43:32];
            r_ready <= s_axis_tdata[44];
        end
    end

    kerb_key_scan #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_key_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (accept),
        .i_mask         (r_mask),
        .i_debounce_max (r_debounce_max),
        .o_push         (scan_push),
        .o_done         (scan_done)
    );

    kerb_detent u_detent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_enc_a (s_axis_tdata[16]),
        .i_enc_b (s_axis_tdata[17]),
        .i_clear (page_clear),
        .o_acc   (det_acc)
    );

    // Extra keys, one per tail cycle, after the matrix keys.
    always_comb begin
        steps      = (r_detent_steps == 7'd0) ? 7'd1 : r_detent_steps;
        acc_w      = 9'(det_acc);
        steps_w    = $signed({2'b00, steps});
        tail_push  = '0;
        page_clear = 1'b0;
        if (r_state == ST_TAIL) begin
            unique case (r_extra)
                EX_ENTER: tail_push = '{valid: !r_sw_n, code: USE_ENTER};
                EX_F12:   tail_push = '{valid: r_touch, code: USE_F12};
                EX_LEFT:  tail_push = '{valid: r_joy_x < r_joy_low, code: USE_LEFT};
                EX_RIGHT: tail_push = '{valid: r_joy_x > r_joy_high, code: USE_RIGHT};
                EX_DOWN:  tail_push = '{valid: r_joy_y < r_joy_low, code: USE_DOWN};
                EX_UP:    tail_push = '{valid: r_joy_y > r_joy_high, code: USE_UP};
                EX_PAGE: begin
                    if (acc_w >= steps_w) begin
                        tail_push  = '{valid: 1'b1, code: USE_PGUP};
                        page_clear = 1'b1;
                    end else if (acc_w <= -steps_w) begin
                        tail_push  = '{valid: 1'b1, code: USE_PGDN};
                        page_clear = 1'b1;
                    end
                end
                default: tail_push = '0;
            endcase
        end
        push = (r_state == ST_SCAN) ? scan_push : tail_push;
        if (r_state == ST_SCAN && !r_ready) begin
            push.valid = 1'b0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_extra  = r_extra;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = r_ready ? ST_TAIL : ST_IDLE;
                    n_extra = EX_ENTER;
                end
            end
            ST_TAIL: begin
                if (r_extra == EX_PAGE) begin
                    n_state = ST_OUT;
                end else begin
                    n_extra = t_extra'(3'(r_extra) + 3'd1);
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_extra <= EX_ENTER;
        end else begin
            r_state <= n_state;
            r_extra <= n_extra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= '0;
        end else if (push.valid && r_cnt < 3'(REPORT_SLOTS)) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < SLOT_MAX; i++) begin
                r_list[i] <= 8'h00;
            end
        end else if (push.valid && r_cnt < 3'(REPORT_SLOTS)) begin
            r_list[r_cnt] <= push.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_slot <= r_list;
            r_out_cnt  <= r_cnt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_cnt, r_out_slot[5], r_out_slot[4],
                            r_out_slot[3], r_out_slot[2], r_out_slot[1], r_out_slot[0]};

endmodule

/* rtl/kerb_ram.sv */
module kerb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kerb_key_scan.sv */
module kerb_key_scan
    import kerb_pkg::*;
#(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_mask,
    input  logic [2:0]  i_debounce_max,
    output t_push       o_push,
    output logic        o_done
);

    localparam int NKEYS = ROWS * COLS;
    localparam int IW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

    // Issue stage: read address for the next key.
    logic          r_busy;
    logic [IW-1:0] r_iss_idx;
    logic [RW-1:0] r_iss_row;
    logic [CW-1:0] r_iss_col;
    logic          iss_last;

    // Update stage: read data has arrived for this key.
    logic          r_dv;
    logic          r_d_last;
    logic          r_d_vld;
    logic [IW-1:0] r_d_idx;
    logic [RW-1:0] r_d_row;
    logic [CW-1:0] r_d_col;

    logic [NKEYS-1:0] r_vld;
    logic [3:0]       rd_data;
    logic [3:0]       cur;
    logic [3:0]       upd;
    logic [2:0]       acc;
    logic             stable;
    logic             down;
    logic [6:0]       idx_w;
    logic [7:0]       code;

    assign iss_last = (r_iss_idx == IW'(NKEYS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dv   <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_dv <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && iss_last) begin
                r_busy <= 1'b0;
            end
            if (r_dv) begin
                r_vld[r_d_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_iss_idx <= '0;
            r_iss_row <= '0;
            r_iss_col <= '0;
        end else if (r_busy) begin
            r_iss_idx <= r_iss_idx + IW'(1);
            if (r_iss_col == CW'(COLS - 1)) begin
                r_iss_col <= '0;
                r_iss_row <= r_iss_row + RW'(1);
            end else begin
                r_iss_col <= r_iss_col + CW'(1);
            end
        end
        r_d_idx  <= r_iss_idx;
        r_d_row  <= r_iss_row;
        r_d_col  <= r_iss_col;
        r_d_last <= iss_last;
        r_d_vld  <= r_vld[r_iss_idx];
    end

    kerb_ram #(
        .WIDTH (4),
        .DEPTH (NKEYS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_dv),
        .i_waddr (r_d_idx),
        .i_wdata (upd),
        .i_re    (r_busy),
        .i_raddr (r_iss_idx),
        .o_rdata (rd_data)
    );

    // A key never written since reset reads as idle.
    always_comb begin
        cur   = r_d_vld ? rd_data : 4'd0;
        idx_w = 7'(r_d_idx);
        down  = (idx_w < 7'd16) && i_mask[idx_w[3:0]];
        acc   = cur[2:0];
        if (down && acc < i_debounce_max) begin
            acc = acc + 3'd1;
        end else if (!down && acc != 3'd0) begin
            acc = acc - 3'd1;
        end
        stable = cur[3];
        if (acc == i_debounce_max) begin
            stable = 1'b1;
        end
        if (acc == 3'd0) begin
            stable = 1'b0;
        end
        upd  = {stable, acc};
        code = usage_code(3'(r_d_row), 3'(r_d_col));
    end

    assign o_push.valid = r_dv && stable && (code != 8'h00);
    assign o_push.code  = code;
    assign o_done       = r_dv && r_d_last;

endmodule

/* rtl/kerb_detent.sv */
module kerb_detent
    import kerb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_enc_a,
    input  logic              i_enc_b,
    input  logic              i_clear,
    output logic signed [7:0] o_acc
);

    logic [1:0]        r_prev;
    logic signed [7:0] r_acc;
    logic signed [8:0] sum;
    logic signed [7:0] n_acc;

    always_comb begin
        sum = 9'(r_acc) + 9'(quad_step({r_prev, i_enc_a, i_enc_b}));
        if (sum > 9'sd127) begin
            n_acc = 8'sd127;
        end else if (sum < -9'sd127) begin
            n_acc = -8'sd127;
        end else begin
            n_acc = sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 2'b11;
            r_acc  <= '0;
        end else if (i_step) begin
            r_prev <= {i_enc_a, i_enc_b};
            r_acc  <= n_acc;
        end else if (i_clear) begin
            r_acc <= '0;
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/kerb_checker.sv */
module kerb_checker
    import kerb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] i_m_tdata
);

    // A held report must not change while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("report changed while stalled");

    // The slot count never exceeds the list length.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[50:48] <= 3'(SLOT_MAX))
        else $error("slot count out of range");

    // An empty report carries no codes.
    a_empty_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[50:48] == 3'd0 |-> i_m_tdata[47:0] == 48'd0)
        else $error("empty report has codes");

    // A tick is worked on alone: the input closes once a transfer is taken.
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input taken during a scan");

    // A report cannot appear in the cycle right after a tick is taken.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !$rose(i_m_tvalid))
        else $error("report appeared too early");

endmodule

bind keypad_encoder_report_builder kerb_checker u_kerb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
